### src/tcl_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tcl_pkg
// Shared types, register indexes and glyph tables for the text cursor layout
// block.
// ----------------------------------------------------------------------------
package tcl_pkg;

    // Configuration port geometry
    localparam int unsigned CFG_INDEX_W = 3;
    localparam int unsigned CFG_DATA_W  = 24;

    // Register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_ORIGIN_X      = 3'd0,
        REG_ORIGIN_Y      = 3'd1,
        REG_ATLAS_U       = 3'd2,
        REG_ATLAS_V       = 3'd3,
        REG_ATLAS_PALETTE = 3'd4,
        REG_TEXT_COLOR    = 3'd5
    } cfg_reg_t;

    // Default layout steps
    localparam int unsigned DEF_TAB_STOP   = 32;
    localparam int unsigned DEF_LINE_STEP  = 10;
    localparam int unsigned DEF_SPACE_STEP = 4;

    // Character codes
    localparam logic [7:0] CHAR_TAB        = 8'h09;
    localparam logic [7:0] CHAR_NEWLINE    = 8'h0A;
    localparam logic [7:0] CHAR_SPACE      = 8'h20;
    localparam logic [7:0] CHAR_FONT_FIRST = 8'h21;
    localparam logic [7:0] CHAR_FONT_LAST  = 8'h7F;
    localparam logic [7:0] CHAR_INVALID    = 8'h7F;
    localparam logic [7:0] CHAR_BTN_FIRST  = 8'h80;
    localparam logic [7:0] CHAR_BTN_NAV    = 8'h82;
    localparam logic [7:0] CHAR_BTN_LAST   = 8'h8D;
    localparam logic [7:0] CHAR_GRID_BASE  = 8'h20;

    // Draw kinds
    localparam logic DRAW_FONT   = 1'b0;
    localparam logic DRAW_BUTTON = 1'b1;

    // Button codes
    localparam logic [3:0] BTN_NAVIGATE = 4'd0;

    // Draw geometry and colors
    localparam logic [3:0]  FONT_HEIGHT    = 4'd9;
    localparam logic [7:0]  FONT_CELL_W    = 8'd6;
    localparam logic [7:0]  FONT_CELL_H    = 8'd9;
    localparam logic [3:0]  BTN_HEIGHT     = 4'd12;
    localparam logic [3:0]  BTN_NAV_WIDTH  = 4'd12;
    localparam logic [3:0]  BTN_WIDTH      = 4'd14;
    localparam logic [23:0] BUTTON_COLOR   = 24'h808080;
    localparam logic [23:0] TEXT_COLOR_RST = 24'h808080;

    // Glyph widths for bytes 0x21..0x7F
    localparam int unsigned GLYPH_COUNT = 95;
    localparam logic [3:0] GLYPH_W [GLYPH_COUNT] = '{
        4'd2, 4'd4, 4'd6, 4'd6, 4'd6, 4'd6, 4'd2, 4'd3, 4'd3, 4'd4, 4'd6, 4'd3, 4'd6,
        4'd2, 4'd6,
        4'd6, 4'd6, 4'd6, 4'd6, 4'd6, 4'd6, 4'd6, 4'd6, 4'd6, 4'd6, 4'd2, 4'd3, 4'd6,
        4'd6, 4'd6, 4'd6,
        4'd6, 4'd6, 4'd6, 4'd6, 4'd6, 4'd6, 4'd6, 4'd6, 4'd6, 4'd4, 4'd5, 4'd6, 4'd6,
        4'd6, 4'd6, 4'd6,
        4'd6, 4'd6, 4'd6, 4'd6, 4'd6, 4'd6, 4'd6, 4'd6, 4'd6, 4'd6, 4'd6, 4'd3, 4'd6,
        4'd3, 4'd4, 4'd6,
        4'd3, 4'd6, 4'd6, 4'd6, 4'd6, 4'd6, 4'd5, 4'd6, 4'd5, 4'd2, 4'd4, 4'd5, 4'd2,
        4'd6, 4'd5, 4'd6,
        4'd6, 4'd6, 4'd6, 4'd6, 4'd5, 4'd5, 4'd6, 4'd6, 4'd6, 4'd6, 4'd5, 4'd4, 4'd2,
        4'd4, 4'd6, 4'd6
    };

    // Input item
    typedef struct packed {
        logic [7:0] char_code;
        logic       string_start;
    } char_item_t;

    // Result item
    typedef struct packed {
        logic               draw_kind;
        logic [3:0]         button_code;
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic [7:0]         tex_u;
        logic [7:0]         tex_v;
        logic [3:0]         draw_width;
        logic [3:0]         draw_height;
        logic [23:0]        draw_color;
        logic [15:0]        tex_palette;
    } draw_item_t;

endpackage : tcl_pkg
`default_nettype wire

### src/text_cursor_layout.sv
`default_nettype none
// ----------------------------------------------------------------------------
// text_cursor_layout
// Character stream to draw list: keeps a text cursor and emits one sprite or
// button-glyph draw per byte other than tab, newline and space.
// ----------------------------------------------------------------------------
// Bytes enter on the char channel and draws leave on the draw channel; tab,
// newline and space only move the cursor and give no draw. The block takes
// one byte every cycle. A draw is presented on the draw channel once its byte
// has passed the input register and then the result register. Throughput is
// set by the single cursor update stage: the tab rounding path (add, magnitude,
// remainder tables, correction, add) and the glyph ROM lookup sit between the
// input register and the cursor/result registers. The char channel stalls only
// when a byte that makes a draw finds the result register full and stalled.
// Configuration writes take effect at once and are meant for idle periods;
// writing an origin does not move the cursor until the next string start,
// though a newline returns x to the current origin x.
// ----------------------------------------------------------------------------
module text_cursor_layout #(
    parameter int unsigned TAB_STOP   = tcl_pkg::DEF_TAB_STOP,
    parameter int unsigned LINE_STEP  = tcl_pkg::DEF_LINE_STEP,
    parameter int unsigned SPACE_STEP = tcl_pkg::DEF_SPACE_STEP
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    // configuration
    input  wire logic                               cfg_we,
    input  wire logic [tcl_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire logic [tcl_pkg::CFG_DATA_W-1:0]     cfg_data,
    // characters in
    input  wire logic                               char_valid,
    output logic                                    char_stall,
    input  wire tcl_pkg::char_item_t                char_item,
    // draws out
    output logic                                    draw_valid,
    input  wire logic                               draw_stall,
    output tcl_pkg::draw_item_t                     draw_item
);
    import tcl_pkg::*;

    // Remainder width for the tab stop, wide enough to hold TAB_STOP itself
    localparam int unsigned RW = $clog2(TAB_STOP + 1);

    // Configuration registers
    logic signed [15:0] origin_x_reg;
    logic signed [15:0] origin_y_reg;
    logic [7:0]         atlas_u_reg;
    logic [7:0]         atlas_v_reg;
    logic [15:0]        atlas_palette_reg;
    logic [23:0]        text_color_reg;

    // Pipeline and cursor registers
    logic               in_valid_reg;
    char_item_t         in_item_reg;
    logic               out_valid_reg;
    logic               out_valid_next;
    draw_item_t         out_item_reg;
    draw_item_t         out_item_next;
    logic [15:0]        cursor_x_reg;
    logic [15:0]        cursor_x_next;
    logic [15:0]        cursor_y_reg;
    logic [15:0]        cursor_y_next;

    // Handshake terms
    logic               has_draw;
    logic               out_free;
    logic               fire;
    logic               in_load;

    // Working values
    logic [7:0]         code;
    logic [15:0]        base_x;
    logic [15:0]        base_y;
    logic [15:0]        tab_t;
    logic [15:0]        tab_mag;
    logic [RW:0]        rem_sum;
    logic [RW:0]        rem_val;
    logic [15:0]        tab_x;
    logic [7:0]         font_code;
    logic [6:0]         glyph_idx;
    logic [6:0]         grid_idx;
    logic [3:0]         glyph_width;
    logic [3:0]         btn_width;
    logic [RW-1:0]      hi_mod_tab [256];
    logic [RW-1:0]      lo_mod_tab [256];

    // Build the remainder tables for the high and low byte of a magnitude
    for (genvar gi = 0; gi < 256; gi++) begin : g_rem_tab
        localparam int unsigned HI_MOD = (gi * 256) % TAB_STOP;
        localparam int unsigned LO_MOD = gi % TAB_STOP;
        assign hi_mod_tab[gi] = RW'(HI_MOD);
        assign lo_mod_tab[gi] = RW'(LO_MOD);
    end

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_x_reg      <= '0;
            origin_y_reg      <= '0;
            atlas_u_reg       <= '0;
            atlas_v_reg       <= '0;
            atlas_palette_reg <= '0;
            text_color_reg    <= TEXT_COLOR_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_ORIGIN_X:      origin_x_reg      <= cfg_data[15:0];
                REG_ORIGIN_Y:      origin_y_reg      <= cfg_data[15:0];
                REG_ATLAS_U:       atlas_u_reg       <= cfg_data[7:0];
                REG_ATLAS_V:       atlas_v_reg       <= cfg_data[7:0];
                REG_ATLAS_PALETTE: atlas_palette_reg <= cfg_data[15:0];
                REG_TEXT_COLOR:    text_color_reg    <= cfg_data[23:0];
                default:           ;
            endcase
        end
    end

    // Pick the cursor base: origin on a string start
    assign code   = in_item_reg.char_code;
    assign base_x = in_item_reg.string_start ? origin_x_reg : cursor_x_reg;
    assign base_y = in_item_reg.string_start ? origin_y_reg : cursor_y_reg;

    // Round x up to the next tab stop, remainder truncating toward zero
    always_comb
    begin
        tab_t   = base_x + 16'(TAB_STOP - 1);
        tab_mag = tab_t[15] ? (16'd0 - tab_t) : tab_t;
        rem_sum = {1'b0, hi_mod_tab[tab_mag[15:8]]} + {1'b0, lo_mod_tab[tab_mag[7:0]]};
        rem_val = (rem_sum >= (RW+1)'(TAB_STOP)) ? rem_sum - (RW+1)'(TAB_STOP) : rem_sum;
        tab_x   = tab_t[15] ? tab_t + 16'(rem_val) : tab_t - 16'(rem_val);
    end

    // Map stray and high bytes onto the invalid glyph, then look up the ROM
    always_comb
    begin
        font_code   = (code < CHAR_FONT_FIRST || code > CHAR_FONT_LAST) ? CHAR_INVALID : code;
        glyph_idx   = 7'(font_code - CHAR_FONT_FIRST);
        grid_idx    = 7'(font_code - CHAR_GRID_BASE);
        glyph_width = GLYPH_W[glyph_idx];
        btn_width   = (code <= CHAR_BTN_NAV) ? BTN_NAV_WIDTH : BTN_WIDTH;
    end

    // Decide the draw and the cursor move for the held byte
    always_comb
    begin
        has_draw      = 1'b1;
        cursor_x_next = base_x;
        cursor_y_next = base_y;
        out_item_next = out_item_reg;
        priority if (code == CHAR_TAB)
        begin
            has_draw      = 1'b0;
            cursor_x_next = tab_x;
        end
        else if (code == CHAR_NEWLINE)
        begin
            has_draw      = 1'b0;
            cursor_x_next = origin_x_reg;
            cursor_y_next = base_y + 16'(LINE_STEP);
        end
        else if (code == CHAR_SPACE)
        begin
            has_draw      = 1'b0;
            cursor_x_next = base_x + 16'(SPACE_STEP);
        end
        else if (code >= CHAR_BTN_FIRST && code <= CHAR_BTN_LAST)
        begin
            out_item_next.draw_kind   = DRAW_BUTTON;
            out_item_next.button_code = (code <= CHAR_BTN_NAV) ? BTN_NAVIGATE
                                                                : 4'(code - CHAR_BTN_NAV);
            out_item_next.pos_x       = base_x;
            out_item_next.pos_y       = base_y - 16'd1;
            out_item_next.tex_u       = '0;
            out_item_next.tex_v       = '0;
            out_item_next.draw_width  = btn_width;
            out_item_next.draw_height = BTN_HEIGHT;
            out_item_next.draw_color  = BUTTON_COLOR;
            out_item_next.tex_palette = '0;
            cursor_x_next             = base_x + 16'(btn_width);
        end
        else
        begin
            out_item_next.draw_kind   = DRAW_FONT;
            out_item_next.button_code = BTN_NAVIGATE;
            out_item_next.pos_x       = base_x;
            out_item_next.pos_y       = base_y;
            out_item_next.tex_u       = atlas_u_reg + 8'(grid_idx[3:0]) * FONT_CELL_W;
            out_item_next.tex_v       = atlas_v_reg + 8'(grid_idx[6:4]) * FONT_CELL_H;
            out_item_next.draw_width  = glyph_width;
            out_item_next.draw_height = FONT_HEIGHT;
            out_item_next.draw_color  = text_color_reg;
            out_item_next.tex_palette = atlas_palette_reg;
            cursor_x_next             = base_x + 16'(glyph_width);
        end
    end

    // Advance the held byte when its draw has room, or when it makes none
    assign out_free   = !out_valid_reg || !draw_stall;
    assign fire       = in_valid_reg && (!has_draw || out_free);
    assign in_load    = !in_valid_reg || fire;
    assign char_stall = !in_load;

    always_comb
    begin
        out_valid_next = out_valid_reg && draw_stall;
        if (fire && has_draw)
        begin
            out_valid_next = 1'b1;
        end
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            cursor_x_reg  <= '0;
            cursor_y_reg  <= '0;
        end
        else
        begin
            if (in_load)
            begin
                in_valid_reg <= char_valid;
            end
            out_valid_reg <= out_valid_next;
            if (fire)
            begin
                cursor_x_reg <= cursor_x_next;
                cursor_y_reg <= cursor_y_next;
            end
        end
    end

    // Capture payloads
    always_ff @(posedge clk)
    begin
        if (in_load && char_valid)
        begin
            in_item_reg <= char_item;
        end
        if (fire && has_draw)
        begin
            out_item_reg <= out_item_next;
        end
    end

    assign draw_valid = out_valid_reg;
    assign draw_item  = out_item_reg;

`ifndef NO_ASSERTIONS
    // The cursor moves only when a byte is handled
    assert property (@(posedge clk) disable iff (!rst_n)
        !fire |=> $stable(cursor_x_reg) && $stable(cursor_y_reg))
        else $error("cursor moved without a handled byte");

    // A byte that makes a draw never overwrites a stalled draw
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && draw_stall |=> $stable(out_item_reg))
        else $error("stalled draw overwritten");

    // Button glyphs carry the fixed height and color
    assert property (@(posedge clk) disable iff (!rst_n)
        draw_valid && draw_item.draw_kind == DRAW_BUTTON |->
            draw_item.draw_height == BTN_HEIGHT && draw_item.draw_color == BUTTON_COLOR)
        else $error("button draw with wrong height or color");

    // Font sprites have the font height and a nonzero width
    assert property (@(posedge clk) disable iff (!rst_n)
        draw_valid && draw_item.draw_kind == DRAW_FONT |->
            draw_item.draw_height == FONT_HEIGHT && draw_item.draw_width != 4'd0)
        else $error("font draw with bad size");
`endif

endmodule : text_cursor_layout
`default_nettype wire
